>>> hw/rtl/rid_pkg.sv
`timescale 1ns / 1ps
// Package for the radix integer-to-digits core: widths, radix constants,
// controller states, command and status structs, digit character function.
// No dependencies.
package rid_pkg;

  localparam int VALUE_W       = 64;
  localparam int BASE_W        = 6;
  localparam int CHAR_W        = 7;
  localparam int DIGIT_W       = 6;
  localparam int DIGIT_STORE   = 64;
  localparam int MAX_DIGITS    = 64;
  localparam int DIGIT_CAP     = (MAX_DIGITS < 1) ? 1 :
                                 ((MAX_DIGITS > DIGIT_STORE) ? DIGIT_STORE : MAX_DIGITS);
  localparam int CNT_W         = $clog2(DIGIT_STORE + 1);
  localparam int IDX_W         = $clog2(DIGIT_STORE);
  localparam int BITS_PER_STEP = 8;
  localparam int STEPS         = VALUE_W / BITS_PER_STEP;
  localparam int STEP_W        = $clog2(STEPS);

  localparam logic [BASE_W-1:0] DEFAULT_RADIX = BASE_W'(10);
  localparam logic [BASE_W-1:0] LOWEST_RADIX  = BASE_W'(2);
  localparam logic [BASE_W-1:0] HIGHEST_RADIX = BASE_W'(36);

  localparam logic [CHAR_W-1:0] CHAR_ZERO = CHAR_W'(48);
  localparam logic [CHAR_W-1:0] CHAR_NINE = CHAR_W'(57);
  localparam logic [CHAR_W-1:0] CHAR_A    = CHAR_W'(97);
  localparam logic [CHAR_W-1:0] CHAR_Z    = CHAR_W'(122);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_STORE,
    ST_FETCH,
    ST_EMIT
  } rid_state_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic store;
    logic out_load;
  } rid_cmd_t;

  typedef struct packed {
    logic step_last;
    logic val_zero;
    logic count_at_cap;
    logic ptr_zero;
  } rid_sts_t;

  function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DIGIT_W'(10)) begin
      c = CHAR_ZERO + CHAR_W'(d);
    end else begin
      c = CHAR_A + CHAR_W'(d) - CHAR_W'(10);
    end
    return c;
  endfunction

endpackage

>>> hw/rtl/rid_if.sv
`timescale 1ns / 1ps
// Valid/ready channels of the radix integer-to-digits core: input words and
// digit words. Depends on rid_pkg.
interface rid_in_if;
  logic                          valid;
  logic                          ready;
  logic [rid_pkg::VALUE_W-1:0]   number;
  logic [rid_pkg::BASE_W-1:0]    base;

  modport source (output valid, output number, output base, input ready);
  modport sink   (input valid, input number, input base, output ready);
endinterface

interface rid_out_if;
  logic                          valid;
  logic                          ready;
  logic [rid_pkg::CHAR_W-1:0]    digit_char;
  logic                          last;

  modport source (output valid, output digit_char, output last, input ready);
  modport sink   (input valid, input digit_char, input last, output ready);
endinterface

>>> hw/rtl/rid_dpath.sv
`timescale 1ns / 1ps
// Datapath: shifting divider (one byte of quotient a cycle), digit memory,
// emit pointer and output word register. Depends on rid_pkg.
module rid_dpath (
  input  logic                          clk,
  input  logic [rid_pkg::VALUE_W-1:0]   number,
  input  logic [rid_pkg::BASE_W-1:0]    base,
  input  rid_pkg::rid_cmd_t             cmd,
  output rid_pkg::rid_sts_t             sts,
  output logic [rid_pkg::CHAR_W-1:0]    digit_char,
  output logic                          last
);
  import rid_pkg::*;

  logic [VALUE_W-1:0]       val_r, val_nxt;
  logic [BASE_W-1:0]        radix_r, radix_nxt;
  logic [DIGIT_W-1:0]       rem_r, rem_nxt;
  logic [STEP_W-1:0]        step_r, step_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [IDX_W-1:0]         ptr_r, ptr_nxt;
  logic [DIGIT_W-1:0]       rd_data_r;
  logic [CHAR_W-1:0]        char_r, char_nxt;
  logic                     last_r, last_nxt;
  logic [DIGIT_W-1:0]       dig_mem [DIGIT_STORE];

  logic [DIGIT_W-1:0]       div_rem;
  logic [BITS_PER_STEP-1:0] div_q;

  always_comb begin
    logic [DIGIT_W:0] trial;
    div_rem = rem_r;
    div_q   = '0;
    for (int i = 0; i < BITS_PER_STEP; i++) begin
      trial = {div_rem, val_r[VALUE_W-1-i]};
      if (trial >= {1'b0, radix_r}) begin
        div_rem                    = DIGIT_W'(trial - {1'b0, radix_r});
        div_q[BITS_PER_STEP-1-i]   = 1'b1;
      end else begin
        div_rem = trial[DIGIT_W-1:0];
      end
    end
  end

  always_comb begin
    val_nxt   = val_r;
    radix_nxt = radix_r;
    rem_nxt   = rem_r;
    step_nxt  = step_r;
    count_nxt = count_r;
    ptr_nxt   = ptr_r;
    char_nxt  = char_r;
    last_nxt  = last_r;
    if (cmd.load) begin
      val_nxt   = number;
      radix_nxt = (base < LOWEST_RADIX || base > HIGHEST_RADIX) ? DEFAULT_RADIX : base;
      rem_nxt   = '0;
      step_nxt  = '0;
      count_nxt = '0;
    end
    if (cmd.div_step) begin
      val_nxt  = {val_r[VALUE_W-BITS_PER_STEP-1:0], div_q};
      rem_nxt  = div_rem;
      step_nxt = step_r + STEP_W'(1);
    end
    if (cmd.store) begin
      rem_nxt   = '0;
      step_nxt  = '0;
      count_nxt = count_r + CNT_W'(1);
      ptr_nxt   = count_r[IDX_W-1:0];
    end
    if (cmd.out_load) begin
      char_nxt = digit_to_char(rd_data_r);
      last_nxt = (ptr_r == '0);
      ptr_nxt  = ptr_r - IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    val_r   <= val_nxt;
    radix_r <= radix_nxt;
    rem_r   <= rem_nxt;
    step_r  <= step_nxt;
    count_r <= count_nxt;
    ptr_r   <= ptr_nxt;
    char_r  <= char_nxt;
    last_r  <= last_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      dig_mem[count_r[IDX_W-1:0]] <= rem_r;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= dig_mem[ptr_r];
  end

  assign sts.step_last    = (step_r == STEP_W'(STEPS - 1));
  assign sts.val_zero     = (val_r == '0);
  assign sts.count_at_cap = (count_r == CNT_W'(DIGIT_CAP - 1));
  assign sts.ptr_zero     = (ptr_r == '0);

  assign digit_char = char_r;
  assign last       = last_r;

endmodule

>>> hw/rtl/rid_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences load, divide, store, fetch and emit, and owns the
// input ready and output valid. Depends on rid_pkg.
module rid_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_ready,
  output logic              out_valid,
  input  rid_pkg::rid_sts_t sts,
  output rid_pkg::rid_cmd_t cmd
);
  import rid_pkg::*;

  rid_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       emit_ok;

  assign emit_ok = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (sts.step_last) state_nxt = ST_STORE;
      end
      ST_STORE: begin
        state_nxt = (sts.val_zero || sts.count_at_cap) ? ST_FETCH : ST_DIVIDE;
      end
      ST_FETCH: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_ok) state_nxt = sts.ptr_zero ? ST_IDLE : ST_FETCH;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_DIVIDE: cmd.div_step = 1'b1;
      ST_STORE:  cmd.store    = 1'b1;
      ST_FETCH:  cmd          = '0;
      ST_EMIT:   cmd.out_load = emit_ok;
      default:   cmd          = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> hw/rtl/radix_integer_to_digits_core.sv
`timescale 1ns / 1ps
// Radix integer-to-digits core: top level joining controller and datapath.
// Depends on rid_pkg, rid_if, rid_ctrl, rid_dpath.
//
// Usage:
//   in_word carries a 64-bit unsigned number and a 6-bit base; a base
//   outside 2 to 36 is taken as 10. For each input word the core sends one
//   out_word per digit, lower-case ASCII, most significant first, with last
//   set on the final digit. Zero gives the single digit '0'. At most
//   MAX_DIGITS digits are sent; higher-order digits are dropped.
//   The core takes one word at a time. Each digit is found by divide steps
//   (one quotient byte per cycle) and a store step, then read from the digit
//   memory and registered in the output word register. in_word.ready is high
//   only between words; the next word is taken while the last digit still
//   waits in the output register.
//   Reset (rst_n low, synchronous) drops any word in progress and clears
//   out_word.valid. When the receiver stalls, the output word holds and
//   digit emission pauses; no digit is lost.
module radix_integer_to_digits_core (
  input  logic       clk,
  input  logic       rst_n,
  rid_in_if.sink     in_word,
  rid_out_if.source  out_word
);
  import rid_pkg::*;

  rid_cmd_t cmd;
  rid_sts_t sts;

  rid_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_word.valid),
    .in_ready  (in_word.ready),
    .out_ready (out_word.ready),
    .out_valid (out_word.valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  rid_dpath u_dpath (
    .clk        (clk),
    .number     (in_word.number),
    .base       (in_word.base),
    .cmd        (cmd),
    .sts        (sts),
    .digit_char (out_word.digit_char),
    .last       (out_word.last)
  );

`ifndef SYNTH
  a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_word.valid |->
      ((out_word.digit_char >= CHAR_ZERO && out_word.digit_char <= CHAR_NINE) ||
       (out_word.digit_char >= CHAR_A && out_word.digit_char <= CHAR_Z)))
    else $error("digit character out of range");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.div_step || cmd.store || cmd.out_load) |-> !in_word.ready)
    else $error("input accepted while a word is in progress");

  a_load_then_divide: assert property (@(posedge clk) disable iff (!rst_n)
    (in_word.valid && in_word.ready) |=> cmd.div_step)
    else $error("accepted word did not start dividing");
`endif

endmodule

>>> tb/tb_radix_integer_to_digits_core.sv
`timescale 1ns / 1ps
// Testbench for radix_integer_to_digits_core: directed and random numbers and radices,
// digit words checked by a built-in predictor. Depends on the core, rid_pkg and rid_if.
module tb_radix_integer_to_digits_core;

  import rid_pkg::*;

  localparam int    CLK_PERIOD   = 20;
  localparam int    IDLE_LIMIT   = 5000;
  localparam int    DRAIN_CYCLES = 800;
  localparam int    MAX_REPORTS  = 10;
  localparam string DIGIT_SET    = "0123456789abcdefghijklmnopqrstuvwxyz";

  typedef struct packed {
    logic [CHAR_W-1:0] digit_char;
    logic              last;
  } digit_word_t;

  logic clk;
  logic rst_n;

  rid_in_if  in_word ();
  rid_out_if out_word ();

  radix_integer_to_digits_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_word),
    .out_word (out_word)
  );

  digit_word_t pending_digits[$];
  int          bad_digits;
  int          idle_cycles;
  int          stall_left;
  bit          sender_gaps;
  bit          receiver_stalls;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end else if (r < 98) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  // Expected digits of one number, most significant first.
  function automatic void predict_digits(input logic [VALUE_W-1:0] number,
                                         input logic [BASE_W-1:0]  base);
    logic [VALUE_W-1:0] rest;
    logic [VALUE_W-1:0] radix;
    logic [DIGIT_W-1:0] low_first [DIGIT_STORE];
    int                 count;
    digit_word_t        w;
    rest  = number;
    radix = (base < LOWEST_RADIX || base > HIGHEST_RADIX) ? VALUE_W'(DEFAULT_RADIX)
                                                         : VALUE_W'(base);
    count = 0;
    do begin
      low_first[count] = DIGIT_W'(rest % radix);
      rest             = rest / radix;
      count++;
    end while (count < DIGIT_CAP && rest != '0);
    for (int k = count - 1; k >= 0; k--) begin
      w.digit_char = CHAR_W'(DIGIT_SET[low_first[k]]);
      w.last       = (k == 0);
      pending_digits.push_back(w);
    end
  endfunction

  task automatic send_number(input logic [VALUE_W-1:0] number, input logic [BASE_W-1:0] base);
    int gap;
    gap = sender_gaps ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_word.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_word.valid  <= 1'b1;
    in_word.number <= number;
    in_word.base   <= base;
    do @(posedge clk); while (in_word.ready !== 1'b1);
    predict_digits(number, base);
  endtask

  task automatic test_zero_values();
    send_number('0, BASE_W'(10));
    send_number('0, BASE_W'(2));
    send_number('0, BASE_W'(36));
    send_number('0, BASE_W'(0));
  endtask

  task automatic test_value_extremes();
    send_number('1, BASE_W'(2));
    send_number('1, BASE_W'(10));
    send_number('1, BASE_W'(16));
    send_number('1, BASE_W'(36));
    send_number(VALUE_W'(1), BASE_W'(2));
    send_number({1'b1, {(VALUE_W-1){1'b0}}}, BASE_W'(2));
    send_number(64'h0123_4567_89ab_cdef, BASE_W'(16));
  endtask

  task automatic test_radix_out_of_range();
    send_number(VALUE_W'(1234567), BASE_W'(0));
    send_number(VALUE_W'(1234567), BASE_W'(1));
    send_number(VALUE_W'(1234567), BASE_W'(37));
    send_number('1, BASE_W'(63));
  endtask

  task automatic test_digit_boundaries();
    send_number(VALUE_W'(35), BASE_W'(36));
    send_number(VALUE_W'(36), BASE_W'(36));
    send_number(VALUE_W'(9), BASE_W'(10));
    send_number(VALUE_W'(10), BASE_W'(10));
    send_number(VALUE_W'(10), BASE_W'(11));
    send_number(VALUE_W'(3), BASE_W'(3));
  endtask

  task automatic test_random_numbers(input int count);
    logic [VALUE_W-1:0] number;
    logic [BASE_W-1:0]  base;
    int                 sel;
    repeat (count) begin
      sel    = $urandom_range(0, 9);
      number = {$urandom, $urandom};
      if (sel >= 4 && sel < 8) begin
        number = number >> $urandom_range(1, 63);
      end else if (sel >= 8) begin
        number = VALUE_W'($urandom_range(0, 40));
      end
      if ($urandom_range(0, 4) == 0) begin
        base = BASE_W'($urandom_range(0, 63));
      end else begin
        base = BASE_W'($urandom_range(2, 36));
      end
      send_number(number, base);
    end
  endtask

  initial begin
    out_word.ready = 1'b0;
    stall_left     = 0;
    forever begin
      @(negedge clk);
      if (receiver_stalls && stall_left == 0) begin
        stall_left = pick_gap();
      end
      if (!receiver_stalls) begin
        stall_left = 0;
      end
      out_word.ready <= (stall_left == 0);
      if (stall_left > 0) begin
        stall_left--;
      end
    end
  end

  always @(posedge clk) begin
    digit_word_t want;
    if (rst_n && out_word.valid === 1'b1 && out_word.ready === 1'b1) begin
      if (pending_digits.size() == 0) begin
        bad_digits++;
        if (bad_digits <= MAX_REPORTS) begin
          $display("unexpected digit word: char %0d last %0b",
                   out_word.digit_char, out_word.last);
        end
      end else begin
        want = pending_digits.pop_front();
        if (out_word.digit_char !== want.digit_char || out_word.last !== want.last) begin
          bad_digits++;
          if (bad_digits <= MAX_REPORTS) begin
            $display("digit mismatch: expected char %0d last %0b, got char %0d last %0b",
                     want.digit_char, want.last, out_word.digit_char, out_word.last);
          end
        end
      end
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_word.valid === 1'b1 && in_word.ready === 1'b1) ||
          (out_word.valid === 1'b1 && out_word.ready === 1'b1)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("tb_radix_integer_to_digits_core: FAIL");
    $finish;
  end

  initial begin
    rst_n           = 1'b0;
    in_word.valid   = 1'b0;
    in_word.number  = '0;
    in_word.base    = '0;
    bad_digits      = 0;
    sender_gaps     = 1'b0;
    receiver_stalls = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    test_zero_values();
    test_value_extremes();
    test_radix_out_of_range();
    test_digit_boundaries();
    test_random_numbers(80);
    sender_gaps     = 1'b1;
    receiver_stalls = 1'b1;
    test_random_numbers(400);

    @(negedge clk);
    in_word.valid <= 1'b0;
    while (pending_digits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (bad_digits == 0 && pending_digits.size() == 0) begin
      $display("tb_radix_integer_to_digits_core: PASS");
    end else begin
      $display("tb_radix_integer_to_digits_core: FAIL");
    end
    $finish;
  end

endmodule
